// ----- rtl/core/msaa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msaa_pkg: shared types and constants of the mark stack arena allocator
// Opcodes, request and result words, and the controller/datapath links.
// ----------------------------------------------------------------------------
package msaa_pkg;

    localparam int ARENA_BYTES_DEF = 1048576;
    localparam int MARK_SLOTS_DEF  = 64;
    localparam int ALIGN_BYTES     = 8;

    localparam logic [2:0] OP_ALLOC     = 3'd0;
    localparam logic [2:0] OP_FREE      = 3'd1;
    localparam logic [2:0] OP_END_ALLOC = 3'd2;
    localparam logic [2:0] OP_SET_POS   = 3'd3;
    localparam logic [2:0] OP_GET_POS   = 3'd4;
    localparam logic [2:0] OP_INIT      = 3'd5;
    localparam logic [2:0] OP_CLEAR     = 3'd6;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [20:0] req_size;
        logic [20:0] req_addr;
        logic [6:0]  req_slot;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [20:0] result_addr;
        logic [6:0]  result_slot;
        logic [20:0] used_bytes;
        logic [20:0] left_bytes;
        logic [6:0]  top_index;
        logic [20:0] end_high_water;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic search;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_search;
        logic search_end;
    } t_dp_stat;

endpackage

// ----- rtl/core/msaa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msaa_ctrl: allocator sequencer
// Takes a word, runs the execute state, then steps the mark search if needed.
// ----------------------------------------------------------------------------
module msaa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  msaa_pkg::t_dp_stat i_stat,
    output logic               o_busy,
    output logic               o_done,
    output msaa_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH
    } t_state;

    t_state r_state;
    logic   r_done;

    assign o_busy       = (r_state != ST_IDLE);
    assign o_done       = r_done;
    assign o_cmd.load   = i_start && (r_state == ST_IDLE);
    assign o_cmd.exec   = (r_state == ST_EXEC);
    assign o_cmd.search = (r_state == ST_SEARCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (i_stat.need_search) begin
                        r_state <= ST_SEARCH;
                    end else begin
                        r_state <= ST_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                ST_SEARCH: begin
                    if (i_stat.search_end) begin
                        r_state <= ST_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/msaa_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msaa_dp: allocator datapath
// Top offset, mark stack memory with valid flops, end high-water, result.
// ----------------------------------------------------------------------------
module msaa_dp #(
    parameter int ARENA_BYTES = msaa_pkg::ARENA_BYTES_DEF,
    parameter int MARK_SLOTS  = msaa_pkg::MARK_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msaa_pkg::t_req     i_req,
    input  msaa_pkg::t_dp_cmd  i_cmd,
    output msaa_pkg::t_dp_stat o_stat,
    output msaa_pkg::t_result  o_result
);

    localparam int TOP_W = $clog2(ARENA_BYTES);
    localparam int EW    = $clog2(ARENA_BYTES + 1);
    localparam int AW    = ((TOP_W > 22) ? TOP_W : 22) + 1;
    localparam int SW    = $clog2(MARK_SLOTS + 1);
    localparam int CSW   = ((SW > 7) ? SW : 7) + 1;
    localparam int DEPTH = MARK_SLOTS + 1;

    localparam logic [AW-1:0]  ARENA_X = AW'(ARENA_BYTES);
    localparam logic [AW-1:0]  ALIGN_M = AW'(msaa_pkg::ALIGN_BYTES - 1);
    localparam logic [CSW-1:0] SLOTS_X = CSW'(MARK_SLOTS);

    msaa_pkg::t_req     r_req;
    logic [TOP_W-1:0]   r_alloc_top, n_alloc_top;
    logic [SW-1:0]      r_mark_top, n_mark_top;
    logic [EW-1:0]      r_end_mark, n_end_mark;
    logic [DEPTH-1:0]   r_valid, n_valid;
    logic               r_ok, n_ok;
    logic [20:0]        r_raddr, n_raddr;
    logic [6:0]         r_rslot, n_rslot;
    logic [SW-1:0]      r_idx, n_idx;

    logic [TOP_W-1:0]   mem [DEPTH];
    logic [TOP_W-1:0]   r_rdata;
    logic               wr_en;
    logic [SW-1:0]      wr_addr;
    logic [TOP_W-1:0]   wr_data;
    logic [SW-1:0]      rd_addr;

    logic [AW-1:0]      size_x, addr_x, top_x, rnd_x, end_x;
    logic [CSW-1:0]     slot_x;
    logic               fits, alloc_ok, pos_ok, hit;
    logic [TOP_W-1:0]   free_off;

    assign size_x   = AW'(r_req.req_size);
    assign addr_x   = AW'(r_req.req_addr);
    assign top_x    = AW'(r_alloc_top);
    assign slot_x   = CSW'(r_req.req_slot);
    assign rnd_x    = (size_x + ALIGN_M) & ~ALIGN_M;
    assign end_x    = ARENA_X - rnd_x;
    assign fits     = (top_x + rnd_x) < ARENA_X;
    assign alloc_ok = (CSW'(r_mark_top) < SLOTS_X) && (size_x != '0)
                      && (size_x < ARENA_X) && fits;
    assign pos_ok   = ((addr_x + size_x) < ARENA_X) && (slot_x <= SLOTS_X);
    // an invalid slot always reads as offset zero
    assign free_off = r_valid[r_mark_top] ? r_rdata : '0;
    assign hit      = r_valid[r_idx] && (AW'(r_rdata) == addr_x);

    assign o_stat.need_search = (r_req.opcode == msaa_pkg::OP_GET_POS)
                                && (r_mark_top != '0);
    assign o_stat.search_end  = hit || (r_idx == r_mark_top);

    // read port: slot 1 to start a search, next slot while searching,
    // otherwise the stack top so a free finds its mark ready
    always_comb begin
        if (i_cmd.exec) begin
            rd_addr = SW'(1);
        end else if (i_cmd.search) begin
            rd_addr = SW'(r_idx + SW'(1));
        end else begin
            rd_addr = r_mark_top;
        end
    end

    always_comb begin
        n_alloc_top = r_alloc_top;
        n_mark_top  = r_mark_top;
        n_end_mark  = r_end_mark;
        n_valid     = r_valid;
        n_ok        = r_ok;
        n_raddr     = r_raddr;
        n_rslot     = r_rslot;
        n_idx       = r_idx;
        wr_en       = 1'b0;
        wr_addr     = SW'(r_mark_top + SW'(1));
        wr_data     = r_alloc_top;
        if (i_cmd.exec) begin
            n_ok    = 1'b0;
            n_raddr = '0;
            n_rslot = '0;
            case (r_req.opcode)
                msaa_pkg::OP_ALLOC: begin
                    if (alloc_ok) begin
                        wr_en          = 1'b1;
                        n_valid[wr_addr] = 1'b1;
                        n_mark_top     = wr_addr;
                        n_raddr        = 21'(r_alloc_top);
                        n_alloc_top    = TOP_W'(top_x + rnd_x);
                        n_ok           = 1'b1;
                    end
                end
                msaa_pkg::OP_FREE: begin
                    if (r_mark_top != '0) begin
                        n_alloc_top         = free_off;
                        n_valid[r_mark_top] = 1'b0;
                        n_mark_top          = SW'(r_mark_top - SW'(1));
                        n_ok                = 1'b1;
                    end
                end
                msaa_pkg::OP_END_ALLOC: begin
                    if (fits) begin
                        n_raddr = 21'(end_x);
                        if (end_x > AW'(r_end_mark)) begin
                            n_end_mark = EW'(end_x);
                        end
                        n_ok = 1'b1;
                    end
                end
                msaa_pkg::OP_SET_POS: begin
                    if (pos_ok) begin
                        wr_en            = 1'b1;
                        wr_addr          = SW'(slot_x);
                        wr_data          = TOP_W'(addr_x);
                        n_valid[wr_addr] = 1'b1;
                        n_mark_top       = SW'(slot_x);
                        n_alloc_top      = TOP_W'(addr_x + size_x);
                        n_ok             = 1'b1;
                    end
                end
                msaa_pkg::OP_GET_POS: begin
                    n_idx = SW'(1);
                end
                msaa_pkg::OP_INIT: begin
                    n_alloc_top = '0;
                    n_mark_top  = '0;
                    n_valid[0]  = 1'b0;
                    n_ok        = 1'b1;
                end
                msaa_pkg::OP_CLEAR: begin
                    n_alloc_top = '0;
                    n_mark_top  = '0;
                    n_valid     = '0;
                    n_ok        = 1'b1;
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end else if (i_cmd.search) begin
            if (hit) begin
                n_ok    = 1'b1;
                n_rslot = 7'(r_idx);
            end
            n_idx = SW'(r_idx + SW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_top <= '0;
            r_mark_top  <= '0;
            r_end_mark  <= '0;
            r_valid     <= '0;
        end else begin
            r_alloc_top <= n_alloc_top;
            r_mark_top  <= n_mark_top;
            r_end_mark  <= n_end_mark;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        r_ok    <= n_ok;
        r_raddr <= n_raddr;
        r_rslot <= n_rslot;
        r_idx   <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (CSW'(rd_addr) <= SLOTS_X) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_result.ok             = r_ok;
    assign o_result.result_addr    = r_raddr;
    assign o_result.result_slot    = r_rslot;
    assign o_result.used_bytes     = 21'(r_alloc_top);
    assign o_result.left_bytes     = 21'(ARENA_X - top_x);
    assign o_result.top_index      = 7'(r_mark_top);
    assign o_result.end_high_water = 21'(r_end_mark);

endmodule

// ----- rtl/core/mark_stack_arena_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mark_stack_arena_allocator_top: bump allocator with a mark stack
// Hands out byte offsets of an arena and keeps a stack of rollback marks.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a request word on i_req and raise start. The word is taken at a
//   clock edge where start is high and busy is low; busy then stays high
//   until the result is out.
//   The result word appears on o_result while o_done is high for exactly one
//   cycle. The receiver has no way to stall it, so sample it on that cycle.
//   During the o_done cycle busy is already low, so the next word may be
//   taken on that same edge.
// Sequence:
//   alloc, free, end_alloc, set_pos, init, clear and get_pos on an empty
//   stack: one execute state, then the result with o_done.
//   get_pos otherwise: after the execute state the search walks the marks
//   from slot 1 to the first match, or to the stack top when none matches.
//   The walk reads one slot per cycle via the mark memory's single read port.
// Reset:
//   Synchronous, active low. Top offset, stack index and end high-water go
//   to zero and every mark is invalid; clear drops all marks at once, no sweep.
// ----------------------------------------------------------------------------
module mark_stack_arena_allocator_top #(
    parameter int ARENA_BYTES = msaa_pkg::ARENA_BYTES_DEF,
    parameter int MARK_SLOTS  = msaa_pkg::MARK_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  msaa_pkg::t_req    i_req,
    output logic              o_done,
    output msaa_pkg::t_result o_result
);

    // command/status link between sequencer and datapath
    msaa_pkg::t_dp_cmd  dp_cmd;
    msaa_pkg::t_dp_stat dp_stat;

    // sequencer: idle -> execute -> (search) -> idle with done strobe
    msaa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd)
    );

    // datapath: allocator state, mark memory and result word
    msaa_dp #(
        .ARENA_BYTES (ARENA_BYTES),
        .MARK_SLOTS  (MARK_SLOTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_result (o_result)
    );

endmodule
